// ===== design/msort_pkg.sv =====
// Shared constants and the signed key compare for the merge sort engine.
package msort_pkg;

    localparam int KEY_W        = 32;
    localparam int MAX_KEYS_DEF = 64;

    // Signed ascending-or-equal compare on raw key bits.
    function automatic logic key_le(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) <= $signed(b);
    endfunction

endpackage

// ===== design/msort_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/merge_sort_engine.sv =====
// Merge sort engine top level: key loading, bottom-up merge sequencer, result emission.
//
// Usage:
//   The slave stream carries one signed 32-bit key per transaction; tlast
//   marks the final key of a set. Up to MAX_KEYS keys are stored; keys that
//   arrive while the store is full are dropped and the set is flagged.
//   After the tlast transaction the block sorts the set ascending (stable)
//   and sends the keys on the master stream, tlast on the final key, tuser
//   set on every key of a set that lost keys.
// Operation:
//   The sort runs ceil(log2 n) passes over a ping-pong pair of RAMs through
//   one shared compare unit; each merge step reads both run heads and then
//   writes one. Emission reads each key from RAM, then loads it into the
//   output register. s_axis_tready is low from the tlast transaction until
//   the last result sits in the output register.
// Reset and stalls:
//   Reset empties the store and the output register. A stalled receiver
//   holds the output register and pauses emission; once the last result is
//   registered, the next set may load while that result waits.
module merge_sort_engine
    import msort_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [KEY_W-1:0] s_axis_tdata,   // [31:0] key_value
    input  logic             s_axis_tlast,   // last_item
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [KEY_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser    // [0] overflow_flag
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int SW = CW + 2;

    // sequencer states
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_ERD  = 3'd5;
    localparam logic [2:0] S_EOUT = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             set_ovf_reg, set_ovf_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [SW-1:0]    width_reg, width_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    a_reg, a_next;
    logic [CW-1:0]    b_reg, b_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [CW-1:0]    e_reg, e_next;
    logic             src_reg, src_next;
    logic             ovalid_reg, ovalid_next;
    logic [KEY_W-1:0] odata_reg, odata_next;
    logic             olast_reg, olast_next;
    logic             ouser_reg, ouser_next;

    logic             in_acc;
    logic             full;
    logic             load_we;
    logic             merge_we;
    logic             take_a;
    logic             emitting;
    logic             oreg_free;
    logic [KEY_W-1:0] merge_data;
    logic [KEY_W-1:0] rd_a, rd_b;
    logic [KEY_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [AW-1:0]    raddr_a;
    logic             we0, we1;
    logic [AW-1:0]    waddr0;
    logic [KEY_W-1:0] wdata0;
    logic [SW-1:0]    n_ext, lo_ext, mid_sum, hi_sum;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign full          = (cnt_reg == CW'(MAX_KEYS));
    assign load_we       = in_acc && !full;
    assign merge_we      = (state_reg == S_WR);
    assign emitting      = (state_reg == S_ERD) || (state_reg == S_EOUT);
    assign oreg_free     = !ovalid_reg || m_axis_tready;

    // read data of the current source store
    assign rd_a = src_reg ? rd1_a : rd0_a;
    assign rd_b = src_reg ? rd1_b : rd0_b;

    // shared compare: take the left run head while it exists and is not larger
    assign take_a     = (a_reg < mid_reg) && ((b_reg >= hi_reg) || key_le(rd_a, rd_b));
    assign merge_data = take_a ? rd_a : rd_b;

    assign raddr_a = emitting ? e_reg[AW-1:0] : a_reg[AW-1:0];

    // bank 0 takes loads and merges out of bank 1; bank 1 takes merges out of bank 0
    assign we0    = load_we || (merge_we && src_reg);
    assign waddr0 = load_we ? cnt_reg[AW-1:0] : k_reg[AW-1:0];
    assign wdata0 = load_we ? s_axis_tdata : merge_data;
    assign we1    = merge_we && !src_reg;

    assign n_ext   = SW'(n_reg);
    assign lo_ext  = SW'(lo_reg);
    assign mid_sum = lo_ext + width_reg;
    assign hi_sum  = lo_ext + (width_reg << 1);

    msort_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_store (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (wdata0),
        .raddr_a (raddr_a),
        .raddr_b (b_reg[AW-1:0]),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    msort_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_merge_scratch (
        .clk     (clk),
        .we      (we1),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_data),
        .raddr_a (raddr_a),
        .raddr_b (b_reg[AW-1:0]),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        set_ovf_next = set_ovf_reg;
        n_next       = n_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        e_next       = e_reg;
        src_next     = src_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        ouser_next   = ouser_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    // store the key, or drop it and flag the set when full
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        n_next       = full ? cnt_reg : cnt_reg + 1'b1;
                        set_ovf_next = full || ovf_reg;
                        cnt_next     = '0;
                        ovf_next     = 1'b0;
                        width_next   = SW'(1);
                        src_next     = 1'b0;
                        state_next   = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                // runs cover the whole set: emit from the current source
                if (width_reg >= n_ext)
                begin
                    e_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                if (lo_reg >= n_reg)
                begin
                    width_next = width_reg << 1;
                    src_next   = !src_reg;
                    state_next = S_PASS;
                end
                else
                begin
                    mid_next   = (mid_sum > n_ext) ? n_reg : mid_sum[CW-1:0];
                    hi_next    = (hi_sum > n_ext) ? n_reg : hi_sum[CW-1:0];
                    a_next     = lo_reg;
                    b_next     = (mid_sum > n_ext) ? n_reg : mid_sum[CW-1:0];
                    k_next     = lo_reg;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // wait for both run heads
                state_next = S_WR;
            end
            S_WR:
            begin
                if (take_a)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = S_SEG;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (oreg_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = rd_a;
                    olast_next  = (e_reg + 1'b1 == n_reg);
                    ouser_next  = set_ovf_reg;
                    if (e_reg + 1'b1 == n_reg)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        e_next     = e_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            set_ovf_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            src_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            set_ovf_reg <= set_ovf_next;
            ovalid_reg  <= ovalid_next;
            src_reg     <= src_next;
        end
    end

    // datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        e_reg     <= e_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        ouser_reg <= ouser_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = ouser_reg;

endmodule

// ===== design/msort_check.sv =====
// Port-level checker for the merge sort engine and its bind.
module msort_check
    import msort_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [KEY_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             m_axis_tuser
);

    logic             in_set_reg;
    logic [KEY_W-1:0] prev_key_reg;
    logic             prev_user_reg;
    logic             out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // track the previous result of the set being emitted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_set_reg    <= 1'b0;
            prev_key_reg  <= '0;
            prev_user_reg <= 1'b0;
        end
        else if (out_acc)
        begin
            in_set_reg    <= !m_axis_tlast;
            prev_key_reg  <= m_axis_tdata;
            prev_user_reg <= m_axis_tuser;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while the set is sorted");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && in_set_reg |-> $signed(m_axis_tdata) >= $signed(prev_key_reg))
        else $error("results out of ascending order");

    a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && in_set_reg |-> m_axis_tuser == prev_user_reg)
        else $error("overflow flag changed within a set");

    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared outside emission");

endmodule

bind merge_sort_engine msort_check u_msort_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/merge_sort_engine_test.sv =====
// Self-checking testbench for merge_sort_engine: streams key sets, checks the sorted output.
module merge_sort_engine_test;
    import msort_pkg::*;

    localparam int SET_CAP      = MAX_KEYS_DEF;
    localparam int RANDOM_ITEMS = 280;
    localparam int LONG_HOLD    = 500;
    localparam int HOLD_AFTER   = 100;
    localparam int SETTLE       = 40;
    localparam int MAX_SHOWN    = 100;
    localparam int DIR_ROWS     = 20;

    typedef struct {
        logic [KEY_W-1:0] value;
        logic             last;
        logic             flag;
    } sorted_key_t;

    // one directed transaction; fixed rows are one-key sets with the result typed in
    typedef struct {
        logic [KEY_W-1:0] key;
        logic             last;
        bit               fixed;
        logic [KEY_W-1:0] fixed_value;
    } stim_row_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [KEY_W-1:0] s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [KEY_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic             m_axis_tuser;

    // model of the set being loaded and the results still owed
    logic signed [KEY_W-1:0] held_keys[$];
    bit                      keys_dropped = 1'b0;
    sorted_key_t             sorted_q[$];

    int items_sent    = 0;
    int sets_done     = 0;
    int overflow_sets = 0;
    int largest_set   = 0;
    int results_seen  = 0;
    int errors        = 0;
    int shown         = 0;

    merge_sort_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Store or drop one accepted key; on the last key, sort the set and queue its results.
    function automatic void absorb_key(logic [KEY_W-1:0] key, logic last);
        sorted_key_t             res;
        logic signed [KEY_W-1:0] v;
        int                      j;
        if (held_keys.size() < SET_CAP)
            held_keys.push_back(key);
        else
            keys_dropped = 1'b1;
        if (!last)
            return;
        // insertion sort, strict compare keeps equal keys in arrival order
        for (int i = 1; i < held_keys.size(); i++)
        begin
            v = held_keys[i];
            j = i;
            while (j > 0 && held_keys[j-1] > v)
            begin
                held_keys[j] = held_keys[j-1];
                j--;
            end
            held_keys[j] = v;
        end
        for (int i = 0; i < held_keys.size(); i++)
        begin
            res.value = held_keys[i];
            res.last  = (i == held_keys.size() - 1);
            res.flag  = keys_dropped;
            sorted_q.push_back(res);
        end
        sets_done++;
        if (keys_dropped)
            overflow_sets++;
        if (held_keys.size() > largest_set)
            largest_set = held_keys.size();
        held_keys.delete();
        keys_dropped = 1'b0;
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mix full-range keys with small values, extremes and repeats so ties are common.
    function automatic logic [KEY_W-1:0] pick_key(logic [KEY_W-1:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 8) - 4;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            8:
            begin
                if ($urandom_range(0, 1) == 0)
                    return 32'h8000_0000 + $urandom_range(0, 3);
                return 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            default:       return prev;
        endcase
    endfunction

    // Offer one key after an optional gap and hold it until the engine takes it.
    task automatic send_key(logic [KEY_W-1:0] key, logic last, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every owed result has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sorted_q.size() != 0);
    endtask

    // stimulus: directed table, then random sets
    initial
    begin
        stim_row_t        rows[DIR_ROWS];
        sorted_key_t      fixed_res;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] prev;
        int               set_len;
        int               set_no;
        int               random_sent;
        bit               quiet;

        rows = '{
            '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},   // most negative key alone
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},   // most positive key alone
            '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},   // zero alone
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},           // extremes reversed
            '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},           // repeats around zero
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},           // alternating bit patterns
            '{32'h5555_5555, 1'b1, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b0, 1'b0, 32'h0},           // already in order
            '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0003, 1'b1, 1'b0, 32'h0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},           // interleaved extremes
            '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'h8000_0000, 1'b1, 1'b0, 32'h0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_key(rows[i].key, rows[i].last, pick_gap(1'b0));
            if (rows[i].fixed)
            begin
                fixed_res.value = rows[i].fixed_value;
                fixed_res.last  = 1'b1;
                fixed_res.flag  = 1'b0;
                sorted_q.push_back(fixed_res);
                sets_done++;
            end
            else
                absorb_key(rows[i].key, rows[i].last);
        end
        drain_results();

        // first two sets overrun and fill the store exactly, the rest are mostly small
        set_no      = 0;
        random_sent = 0;
        prev        = '0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (set_no == 0)
                set_len = SET_CAP + 2;
            else if (set_no == 1)
                set_len = SET_CAP;
            else
            begin
                case ($urandom_range(0, 19))
                    0:          set_len = $urandom_range(SET_CAP - 1, SET_CAP);
                    1:          set_len = $urandom_range(SET_CAP + 1, SET_CAP + 3);
                    2, 3, 4:    set_len = $urandom_range(13, 40);
                    default:    set_len = $urandom_range(1, 12);
                endcase
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++)
            begin
                key = pick_key(prev);
                send_key(key, k == set_len - 1, pick_gap(quiet));
                absorb_key(key, k == set_len - 1);
                prev = key;
                random_sent++;
            end
            set_no++;
            if (set_no == 4)
                drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        $display("Sorted %0d sets from %0d keys (%0d with dropped keys, largest %0d kept), %0d results checked",
                 sets_done, items_sent, overflow_sets, largest_set, results_seen);
        $display("Both streams idled at random; output held off %0d cycles once while input kept coming",
                 LONG_HOLD);
        if (errors == 0)
            $display("** merge_sort_engine: PASSED **");
        else
            $display("** merge_sort_engine: FAILED **");
        $finish;
    end

    // result side: check each transaction, then choose the next tready
    initial
    begin
        sorted_key_t want;
        int          stall_left;
        int          cycle_n;
        bit          eager;
        bit          hold_done;

        stall_left = 0;
        cycle_n    = 0;
        eager      = 1'b0;
        hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (sorted_q.size() == 0)
                begin
                    errors++;
                    if (shown < MAX_SHOWN)
                        $display("%0t: unexpected result key %0d last %0b flag %0b",
                                 $time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                    shown++;
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tlast !== want.last ||
                        m_axis_tuser !== want.flag)
                    begin
                        errors++;
                        if (shown < MAX_SHOWN)
                            $display("%0t: expected key %0d last %0b flag %0b, got key %0d last %0b flag %0b",
                                     $time, $signed(want.value), want.last, want.flag,
                                     $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
                        shown++;
                    end
                end
            end

            cycle_n++;
            if (cycle_n % 64 == 0)
                eager = ($urandom_range(0, 2) == 0);
            // hold off once long enough for the engine to back up into its input
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (eager || $urandom_range(0, 99) < 70)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("** merge_sort_engine: FAILED **");
        $finish;
    end

endmodule
